@@ hdl/depth_forward_warp_zbuffer_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DEPTH_FORWARD_WARP_ZBUFFER_CORE_ASSERT_SVH
`define DEPTH_FORWARD_WARP_ZBUFFER_CORE_ASSERT_SVH

// same-cycle implication
`define DFWZ_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DFWZ_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/dfwz_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfwz_pkg
// Types and constants of the forward depth warp with z-buffer.
// ----------------------------------------------------------------------------
package dfwz_pkg;

   localparam int IMG_W       = 256;
   localparam int IMG_H       = 256;
   localparam int STORE_DEPTH = IMG_W * IMG_H;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COL_W       = $clog2(IMG_W);
   localparam int ROW_W       = $clog2(IMG_H);
   localparam int FRAC_W      = 12;
   localparam longint U_LIM   = longint'(IMG_W) * 4096;
   localparam longint V_LIM   = longint'(IMG_H) * 4096;

   localparam int MUL_A_W   = 48;
   localparam int OP_B_W    = 25;
   localparam int DEN_W     = 24;
   localparam int DIV_N_W   = 64;
   localparam int PROD_W    = MUL_A_W + OP_B_W;
   localparam int RES_W     = 80;
   localparam int ACC_W     = 76;
   localparam int PT_W      = ACC_W - 14;
   localparam int MUL_STEPS = OP_B_W;
   localparam int DIV_STEPS = DIV_N_W;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   localparam logic [2:0] STS_STORED   = 3'd0;
   localparam logic [2:0] STS_INVALID  = 3'd1;
   localparam logic [2:0] STS_BEHIND   = 3'd2;
   localparam logic [2:0] STS_OFF      = 3'd3;
   localparam logic [2:0] STS_OCCLUDED = 3'd4;
   localparam logic [2:0] STS_READ     = 3'd5;

   localparam logic [15:0] BIN_ONE  = 16'd255;
   localparam logic [15:0] BIN_ZERO = 16'd0;

   typedef enum logic [2:0] {
      REG_ROT0, REG_ROT1, REG_ROT2, REG_TRANS,
      REG_FOCAL, REG_PP, REG_FILL, REG_BIN
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_RDCHK, ST_DIVX, ST_DIVY, ST_DOT, ST_ZCHK,
      ST_UMUL, ST_UDIV, ST_VMUL, ST_VDIV, ST_TEST, ST_DONE
   } fsm_state_type;

   typedef struct packed {
      logic              kind;
      logic [7:0]        pix_x;
      logic [7:0]        pix_y;
      logic signed [15:0] pix_value;
      logic signed [15:0] pix_depth;
   } req_item_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         out_x;
      logic [7:0]         out_y;
      logic signed [15:0] out_value;
      logic [15:0]        out_depth;
   } rsp_item_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic              wr_value_en;
      logic [ADDR_W-1:0] addr;
      logic [15:0]       wdepth;
      logic [15:0]       wvalue;
   } store_cmd_type;

   typedef struct packed {
      logic        clr_busy;
      logic [15:0] rdepth;
      logic [15:0] rvalue;
   } store_rsp_type;

   typedef struct packed {
      logic                       start;
      logic                       is_div;
      logic signed [DIV_N_W-1:0]  a;
      logic signed [OP_B_W-1:0]   b;
   } mdu_req_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic signed [RES_W-1:0]  res;
   } mdu_rsp_type;

endpackage

@@ hdl/depth_forward_warp_zbuffer_core.sv @@
`timescale 1ns / 1ps
`include "depth_forward_warp_zbuffer_core_assert.svh"
// ----------------------------------------------------------------------------
// depth_forward_warp_zbuffer_core
// Forward depth warp of splat requests into a z-buffered target store.
// ----------------------------------------------------------------------------
// One request at a time. Read request: accepted in idle, store read in start,
// depth checked in read-check, response issued from done. A splat reaching the
// z-test runs 15 operations on the serial multiply/divide unit: 11 multiplies
// and 4 divides. Invalid source or zero focal length go from start to done.
// Reset clears the depth store; no request is taken while it clears.
// ----------------------------------------------------------------------------
module depth_forward_warp_zbuffer_core import dfwz_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [5:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   fsm_state_type state_ff, state_in;
   req_item_type  item_ff, item_in;
   rsp_item_type  res_ff, res_in;
   rsp_item_type  rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [47:0] rot0_ff, rot1_ff, rot2_ff, trans_ff, focal_ff;
   logic [31:0] pp_ff;
   logic [15:0] fill_ff;
   logic        bin_ff;

   logic [MUL_A_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [PT_W-1:0]    xt_ff, xt_in, yt_ff, yt_in, zt_ff, zt_in;
   logic [15:0]        zsat_ff, zsat_in;
   logic [31:0]        ycl_ff, ycl_in;
   logic [1:0]         r_ff, r_in, c_ff, c_in, rn, cn;
   logic [ACC_W-1:0]   acc_ff, acc_in, acc_sum;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               uok_ff, uok_in;

   mdu_req_type   mdu_req;
   mdu_rsp_type   mdu_rsp;
   store_cmd_type store_cmd;
   store_rsp_type store_rsp;

   logic [23:0]        fx, fy;
   logic [15:0]        cx, cy;
   logic signed [17:0] dx, dy;
   logic signed [33:0] nxp, nyp;
   logic [DIV_N_W-1:0] uv, vv;
   logic               vok, rd_in_range, src_bad, csr_wr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [31:0]        xcl;
   logic               wait_st;

   dfwz_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .req   (mdu_req),
      .rsp   (mdu_rsp)
   );

   dfwz_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (store_cmd),
      .rsp   (store_rsp)
   );

   function automatic rsp_item_type mk_rsp(input logic [2:0] st, input logic [7:0] ox,
                                           input logic [7:0] oy, input logic [15:0] ov,
                                           input logic [15:0] od);
      rsp_item_type r;
      r.status    = st;
      r.out_x     = ox;
      r.out_y     = oy;
      r.out_value = ov;
      r.out_depth = od;
      return r;
   endfunction

   function automatic logic [15:0] read_val(input logic bin, input logic [15:0] v);
      if (bin) begin
         return (v != '0) ? BIN_ONE : BIN_ZERO;
      end
      return v;
   endfunction

   function automatic logic [31:0] clamp32(input logic [PT_W-1:0] v);
      if (&v[PT_W-1:31] || ~|v[PT_W-1:31]) begin
         return v[31:0];
      end
      return v[PT_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   function automatic logic [OP_B_W-1:0] coef_sel(input logic [47:0] row, input logic [1:0] c);
      logic [15:0] k;
      unique case (c)
         2'd0:    k = row[47:32];
         2'd1:    k = row[31:16];
         default: k = row[15:0];
      endcase
      return {{(OP_B_W-16){k[15]}}, k};
   endfunction

   function automatic logic [47:0] rot_sel(input logic [1:0] r, input logic [47:0] r0,
                                           input logic [47:0] r1, input logic [47:0] r2);
      unique case (r)
         2'd0:    return r0;
         2'd1:    return r1;
         default: return r2;
      endcase
   endfunction

   // ---- configuration ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot0_ff  <= 48'h4000_0000_0000;
         rot1_ff  <= 48'h0000_4000_0000;
         rot2_ff  <= 48'h0000_0000_4000;
         trans_ff <= '0;
         focal_ff <= '0;
         pp_ff    <= '0;
         fill_ff  <= '0;
         bin_ff   <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_reg_type'(csr_paddr[5:3]))
            REG_ROT0:  rot0_ff  <= csr_pwdata[47:0];
            REG_ROT1:  rot1_ff  <= csr_pwdata[47:0];
            REG_ROT2:  rot2_ff  <= csr_pwdata[47:0];
            REG_TRANS: trans_ff <= csr_pwdata[47:0];
            REG_FOCAL: focal_ff <= csr_pwdata[47:0];
            REG_PP:    pp_ff    <= csr_pwdata[31:0];
            REG_FILL:  fill_ff  <= csr_pwdata[15:0];
            REG_BIN:   bin_ff   <= csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg_type'(csr_paddr[5:3]))
         REG_ROT0:  csr_prdata = 64'(rot0_ff);
         REG_ROT1:  csr_prdata = 64'(rot1_ff);
         REG_ROT2:  csr_prdata = 64'(rot2_ff);
         REG_TRANS: csr_prdata = 64'(trans_ff);
         REG_FOCAL: csr_prdata = 64'(focal_ff);
         REG_PP:    csr_prdata = 64'(pp_ff);
         REG_FILL:  csr_prdata = 64'(fill_ff);
         REG_BIN:   csr_prdata = 64'(bin_ff);
      endcase
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      xt_ff   <= xt_in;
      yt_ff   <= yt_in;
      zt_ff   <= zt_in;
      zsat_ff <= zsat_in;
      ycl_ff  <= ycl_in;
      r_ff    <= r_in;
      c_ff    <= c_in;
      acc_ff  <= acc_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
      uok_ff  <= uok_in;
   end

   assign fx = focal_ff[47:24];
   assign fy = focal_ff[23:0];
   assign cx = pp_ff[31:16];
   assign cy = pp_ff[15:0];

   assign dx  = $signed({6'b0, item_ff.pix_x, 4'b0}) - $signed({2'b0, cx});
   assign dy  = $signed({6'b0, item_ff.pix_y, 4'b0}) - $signed({2'b0, cy});
   assign nxp = dx * $signed(item_ff.pix_depth);
   assign nyp = dy * $signed(item_ff.pix_depth);

   assign rd_in_range = (int'(item_ff.pix_x) < IMG_W) && (int'(item_ff.pix_y) < IMG_H);
   assign rd_addr     = ADDR_W'(int'(item_ff.pix_y) * IMG_W + int'(item_ff.pix_x));
   assign src_bad     = (bin_ff ? (item_ff.pix_value == 16'sd0)
                                : (item_ff.pix_value <= 16'sd0))
                        || (item_ff.pix_depth <= 16'sd0);

   assign uv  = mdu_rsp.res[DIV_N_W-1:0] + {40'b0, cx, 8'b0};
   assign vv  = mdu_rsp.res[DIV_N_W-1:0] + {40'b0, cy, 8'b0};
   assign vok = !vv[DIV_N_W-1] && (vv[DIV_N_W-2:0] < (DIV_N_W-1)'(V_LIM));
   assign xcl = clamp32(xt_ff);

   assign wait_st = (state_ff == ST_DIVX) || (state_ff == ST_DIVY) || (state_ff == ST_DOT)
                    || (state_ff == ST_UMUL) || (state_ff == ST_UDIV)
                    || (state_ff == ST_VMUL) || (state_ff == ST_VDIV);

   always_comb begin
      rn = (c_ff == 2'd2) ? r_ff + 2'd1 : r_ff;
      cn = (c_ff == 2'd2) ? 2'd0 : c_ff + 2'd1;
      unique case (r_ff)
         2'd0:    acc_sum = (c_ff == 2'd0)
                     ? {{(ACC_W-30){trans_ff[47]}}, trans_ff[47:32], 14'b0} : acc_ff;
         2'd1:    acc_sum = (c_ff == 2'd0)
                     ? {{(ACC_W-30){trans_ff[31]}}, trans_ff[31:16], 14'b0} : acc_ff;
         default: acc_sum = (c_ff == 2'd0)
                     ? {{(ACC_W-30){trans_ff[15]}}, trans_ff[15:0], 14'b0} : acc_ff;
      endcase
      acc_sum = acc_sum + mdu_rsp.res[ACC_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      x_in         = x_ff;
      y_in         = y_ff;
      xt_in        = xt_ff;
      yt_in        = yt_ff;
      zt_in        = zt_ff;
      zsat_in      = zsat_ff;
      ycl_in       = ycl_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      acc_in       = acc_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      uok_in       = uok_ff;
      mdu_req      = '0;
      store_cmd    = '0;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !store_rsp.clr_busy;
            if (req_valid && !store_rsp.clr_busy) begin
               item_in  = req_data;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (item_ff.kind) begin
               if (rd_in_range) begin
                  store_cmd.rd_en = 1'b1;
                  store_cmd.addr  = rd_addr;
                  state_in        = ST_RDCHK;
               end else begin
                  res_in   = mk_rsp(STS_READ, item_ff.pix_x, item_ff.pix_y,
                                    read_val(bin_ff, fill_ff), 16'd0);
                  state_in = ST_DONE;
               end
            end else if (src_bad) begin
               res_in   = mk_rsp(STS_INVALID, 8'd0, 8'd0, 16'd0, 16'd0);
               state_in = ST_DONE;
            end else if (fx == '0 || fy == '0) begin
               res_in   = mk_rsp(STS_OFF, 8'd0, 8'd0, 16'd0, 16'd0);
               state_in = ST_DONE;
            end else begin
               mdu_req.start  = 1'b1;
               mdu_req.is_div = 1'b1;
               mdu_req.a      = {{22{nxp[33]}}, nxp, 8'b0};
               mdu_req.b      = {1'b0, fx};
               state_in       = ST_DIVX;
            end
         end
         ST_RDCHK: begin
            if (store_rsp.rdepth == '0) begin
               res_in = mk_rsp(STS_READ, item_ff.pix_x, item_ff.pix_y,
                               read_val(bin_ff, fill_ff), 16'd0);
            end else begin
               res_in = mk_rsp(STS_READ, item_ff.pix_x, item_ff.pix_y,
                               read_val(bin_ff, store_rsp.rvalue), store_rsp.rdepth);
               store_cmd.wr_en  = 1'b1;
               store_cmd.addr   = rd_addr;
               store_cmd.wdepth = 16'd0;
            end
            state_in = ST_DONE;
         end
         ST_DIVX: begin
            if (mdu_rsp.done) begin
               x_in           = mdu_rsp.res[MUL_A_W-1:0];
               mdu_req.start  = 1'b1;
               mdu_req.is_div = 1'b1;
               mdu_req.a      = {{22{nyp[33]}}, nyp, 8'b0};
               mdu_req.b      = {1'b0, fy};
               state_in       = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (mdu_rsp.done) begin
               y_in          = mdu_rsp.res[MUL_A_W-1:0];
               r_in          = 2'd0;
               c_in          = 2'd0;
               mdu_req.start = 1'b1;
               mdu_req.a     = {{(DIV_N_W-MUL_A_W){x_ff[MUL_A_W-1]}}, x_ff};
               mdu_req.b     = coef_sel(rot0_ff, 2'd0);
               state_in      = ST_DOT;
            end
         end
         ST_DOT: begin
            if (mdu_rsp.done) begin
               acc_in = acc_sum;
               if (c_ff == 2'd2) begin
                  unique case (r_ff)
                     2'd0:    xt_in = acc_sum[ACC_W-1:14];
                     2'd1:    yt_in = acc_sum[ACC_W-1:14];
                     default: zt_in = acc_sum[ACC_W-1:14];
                  endcase
               end
               if (r_ff == 2'd2 && c_ff == 2'd2) begin
                  state_in = ST_ZCHK;
               end else begin
                  r_in          = rn;
                  c_in          = cn;
                  mdu_req.start = 1'b1;
                  mdu_req.b     = coef_sel(rot_sel(rn, rot0_ff, rot1_ff, rot2_ff), cn);
                  unique case (cn)
                     2'd0:    mdu_req.a = {{(DIV_N_W-MUL_A_W){x_ff[MUL_A_W-1]}}, x_ff};
                     2'd1:    mdu_req.a = {{(DIV_N_W-MUL_A_W){y_ff[MUL_A_W-1]}}, y_ff};
                     default: mdu_req.a = {{48{item_ff.pix_depth[15]}}, item_ff.pix_depth};
                  endcase
               end
            end
         end
         ST_ZCHK: begin
            if (zt_ff[PT_W-1] || zt_ff == '0) begin
               res_in   = mk_rsp(STS_BEHIND, 8'd0, 8'd0, 16'd0, 16'd0);
               state_in = ST_DONE;
            end else begin
               zsat_in       = (zt_ff[PT_W-1:16] != '0) ? 16'hFFFF : zt_ff[15:0];
               ycl_in        = clamp32(yt_ff);
               mdu_req.start = 1'b1;
               mdu_req.a     = {{32{xcl[31]}}, xcl};
               mdu_req.b     = {1'b0, fx};
               state_in      = ST_UMUL;
            end
         end
         ST_UMUL: begin
            if (mdu_rsp.done) begin
               mdu_req.start  = 1'b1;
               mdu_req.is_div = 1'b1;
               mdu_req.a      = mdu_rsp.res[DIV_N_W-1:0];
               mdu_req.b      = {9'b0, zsat_ff};
               state_in       = ST_UDIV;
            end
         end
         ST_UDIV: begin
            if (mdu_rsp.done) begin
               uok_in        = !uv[DIV_N_W-1] && (uv[DIV_N_W-2:0] < (DIV_N_W-1)'(U_LIM));
               col_in        = uv[FRAC_W +: COL_W];
               mdu_req.start = 1'b1;
               mdu_req.a     = {{32{ycl_ff[31]}}, ycl_ff};
               mdu_req.b     = {1'b0, fy};
               state_in      = ST_VMUL;
            end
         end
         ST_VMUL: begin
            if (mdu_rsp.done) begin
               mdu_req.start  = 1'b1;
               mdu_req.is_div = 1'b1;
               mdu_req.a      = mdu_rsp.res[DIV_N_W-1:0];
               mdu_req.b      = {9'b0, zsat_ff};
               state_in       = ST_VDIV;
            end
         end
         ST_VDIV: begin
            if (mdu_rsp.done) begin
               if (!uok_ff || !vok) begin
                  res_in   = mk_rsp(STS_OFF, 8'd0, 8'd0, 16'd0, 16'd0);
                  state_in = ST_DONE;
               end else begin
                  row_in          = vv[FRAC_W +: ROW_W];
                  store_cmd.rd_en = 1'b1;
                  store_cmd.addr  = ADDR_W'(int'(vv[FRAC_W +: ROW_W]) * IMG_W
                                            + int'(col_ff));
                  state_in        = ST_TEST;
               end
            end
         end
         ST_TEST: begin
            if (store_rsp.rdepth != '0 && zsat_ff >= store_rsp.rdepth) begin
               res_in = mk_rsp(STS_OCCLUDED, 8'(col_ff), 8'(row_ff),
                               item_ff.pix_value, zsat_ff);
            end else begin
               res_in = mk_rsp(STS_STORED, 8'(col_ff), 8'(row_ff),
                               item_ff.pix_value, zsat_ff);
               store_cmd.wr_en       = 1'b1;
               store_cmd.wr_value_en = 1'b1;
               store_cmd.addr        = ADDR_W'(int'(row_ff) * IMG_W + int'(col_ff));
               store_cmd.wdepth      = zsat_ff;
               store_cmd.wvalue      = item_ff.pix_value;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DFWZ_ASSERT_IMP(a_no_wr_in_clear, store_cmd.wr_en, !store_rsp.clr_busy, "write in clear")
   `DFWZ_ASSERT_IMP(a_done_in_wait, mdu_rsp.done, wait_st, "arithmetic result outside a wait state")
   `DFWZ_ASSERT_IMP(a_idle_unit_free, req_ready, !mdu_rsp.busy, "request taken while unit busy")
   `DFWZ_ASSERT_NXT(a_accept_start, req_valid && req_ready, state_ff == ST_START, "not started")

endmodule

@@ hdl/dfwz_mdu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfwz_mdu
// Shared bit-serial signed multiplier and floor divider.
// ----------------------------------------------------------------------------
module dfwz_mdu import dfwz_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mdu_req_type req,
   output mdu_rsp_type rsp
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               div_ff, div_in;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_N_W-1:0] opa_ff, opa_in;
   logic [OP_B_W-1:0]  opb_ff, opb_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [RES_W-1:0]   res_ff, res_in;

   logic [MUL_A_W-1:0] a_mul, mag_am;
   logic [DIV_N_W-1:0] mag_ad, q_up, r64;
   logic [OP_B_W-1:0]  mag_b;
   logic [DEN_W:0]     trial, diff;
   logic               ge;
   logic [PROD_W-1:0]  r73;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;

      a_mul  = req.a[MUL_A_W-1:0];
      mag_am = a_mul[MUL_A_W-1] ? (~a_mul + 1'b1) : a_mul;
      mag_ad = req.a[DIV_N_W-1] ? (~req.a + 1'b1) : req.a;
      mag_b  = req.b[OP_B_W-1] ? (~req.b + 1'b1) : req.b;

      trial = {acc_ff[DEN_W-1:0], opa_ff[DIV_N_W-1]};
      diff  = trial - {1'b0, opb_ff[DEN_W-1:0]};
      ge    = trial >= {1'b0, opb_ff[DEN_W-1:0]};
      q_up  = opa_ff + DIV_N_W'(acc_ff[DEN_W-1:0] != '0);
      r64   = neg_ff ? (~q_up + 1'b1) : opa_ff;
      r73   = neg_ff ? (~acc_ff + 1'b1) : acc_ff;

      if (busy_ff) begin
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - 1'b1;
            if (div_ff) begin
               acc_in = PROD_W'(ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0]);
               opa_in = {opa_ff[DIV_N_W-2:0], ge};
            end else begin
               acc_in = {acc_ff[PROD_W-2:0], 1'b0}
                      + (opb_ff[OP_B_W-1] ? PROD_W'(opa_ff[MUL_A_W-1:0]) : '0);
               opb_in = {opb_ff[OP_B_W-2:0], 1'b0};
            end
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (div_ff) begin
               res_in = {{(RES_W-DIV_N_W){r64[DIV_N_W-1]}}, r64};
            end else begin
               res_in = {{(RES_W-PROD_W){r73[PROD_W-1]}}, r73};
            end
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         div_in  = req.is_div;
         acc_in  = '0;
         opb_in  = mag_b;
         if (req.is_div) begin
            neg_in = req.a[DIV_N_W-1];
            opa_in = mag_ad;
            cnt_in = CNT_W'(DIV_STEPS);
         end else begin
            neg_in = a_mul[MUL_A_W-1] ^ req.b[OP_B_W-1];
            opa_in = DIV_N_W'(mag_am);
            cnt_in = CNT_W'(MUL_STEPS);
         end
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.res  = res_ff;

endmodule

@@ hdl/dfwz_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfwz_store
// Depth and value memories, registered read, depth memory cleared after reset.
// ----------------------------------------------------------------------------
module dfwz_store import dfwz_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  store_cmd_type cmd,
   output store_rsp_type rsp
);

   logic [15:0] depth_mem [STORE_DEPTH];
   logic [15:0] value_mem [STORE_DEPTH];

   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [15:0]       rdepth_ff;
   logic [15:0]       rvalue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         depth_mem[clr_addr_ff] <= 16'd0;
      end else if (cmd.wr_en) begin
         depth_mem[cmd.addr] <= cmd.wdepth;
      end
      if (cmd.rd_en) begin
         rdepth_ff <= depth_mem[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && cmd.wr_value_en) begin
         value_mem[cmd.addr] <= cmd.wvalue;
      end
      if (cmd.rd_en) begin
         rvalue_ff <= value_mem[cmd.addr];
      end
   end

   assign rsp.clr_busy = clr_busy_ff;
   assign rsp.rdepth   = rdepth_ff;
   assign rsp.rvalue   = rvalue_ff;

endmodule
